// ===== hw/rtl/gkpq_pkg.sv =====
// ----------------------------------------------------------------------------
// gkpq_pkg
// Shared constants and types for the grouped key priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package gkpq_pkg;

  localparam int NODE_SLOTS_DEF      = 16;
  localparam int VALUES_PER_NODE_DEF = 32;
  localparam int KEY_W               = 64;
  localparam int VAL_W               = 64;

  // op codes of the input item
  localparam logic OP_PUT    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // broadcast command from the sequencer to every cell
  typedef struct packed {
    logic ins;         // insert a new node at the found position
    logic grow;        // add the value to the node at the found position
    logic join_front;  // grow extends the window at its front
    logic rm;          // take one value off the head node
    logic del;         // head node empties: shift the chain left
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gkpq_if.sv =====
// ----------------------------------------------------------------------------
// gkpq_if
// Valid/ready channels for the request and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gkpq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] item_key;
  logic [63:0] item_value;

  modport source (output valid, output op, output item_key, output item_value, input ready);
  modport sink   (input valid, input op, input item_key, input item_value, output ready);
endinterface

interface gkpq_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_out;
  logic [63:0] value_out;
  logic        was_empty;
  logic        overflow;
  logic        empty_now;
  logic        two_distinct_keys;

  modport source (output valid, output key_out, output value_out, output was_empty,
                  output overflow, output empty_now, output two_distinct_keys,
                  input ready);
  modport sink   (input valid, input key_out, input value_out, input was_empty,
                  input overflow, input empty_now, input two_distinct_keys,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gkpq_cell.sv =====
// ----------------------------------------------------------------------------
// gkpq_cell
// One node of the sorted chain: key, slot window bounds and slot bank pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module gkpq_cell #(
  parameter int IDX = 0,
  parameter int VPN = gkpq_pkg::VALUES_PER_NODE_DEF,
  parameter int PW  = 4,
  parameter int FW  = 6
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire gkpq_pkg::ctrl_t         ctrl,
  input  wire [gkpq_pkg::KEY_W-1:0]    item_key,
  input  wire [PW-1:0]                 free_ptr,
  input  wire [PW-1:0]                 head_ptr,
  input  wire                          lt_left,
  input  wire                          left_valid,
  input  wire [gkpq_pkg::KEY_W-1:0]    left_key,
  input  wire [FW-1:0]                 left_front,
  input  wire [FW-1:0]                 left_back,
  input  wire [PW-1:0]                 left_ptr,
  input  wire                          right_valid,
  input  wire [gkpq_pkg::KEY_W-1:0]    right_key,
  input  wire [FW-1:0]                 right_front,
  input  wire [FW-1:0]                 right_back,
  input  wire [PW-1:0]                 right_ptr,
  output logic                         valid,
  output logic [gkpq_pkg::KEY_W-1:0]   key,
  output logic [FW-1:0]                front,
  output logic [FW-1:0]                back,
  output logic [PW-1:0]                ptr,
  output logic                         lt,
  output logic                         at_pos,
  output logic                         hit,
  output logic                         valid_nxt_o,
  output logic [gkpq_pkg::KEY_W-1:0]   key_nxt_o
);

  logic                        valid_r, valid_nxt;
  logic [gkpq_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [FW-1:0]               front_r, front_nxt;
  logic [FW-1:0]               back_r, back_nxt;
  logic [PW-1:0]               ptr_r, ptr_nxt;
  logic                        full;

  assign lt     = valid_r && (key_r < item_key);
  assign at_pos = !lt && lt_left;
  assign full   = (back_r - front_r) == FW'(VPN);
  assign hit    = at_pos && valid_r && (key_r == item_key) && !full;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    ptr_nxt   = ptr_r;
    if (en) begin
      if (ctrl.ins) begin
        if (at_pos) begin
          valid_nxt = 1'b1;
          key_nxt   = item_key;
          front_nxt = '0;
          back_nxt  = FW'(1);
          ptr_nxt   = free_ptr;
        end else if (!lt && left_valid) begin
          // shift right to open the gap
          valid_nxt = left_valid;
          key_nxt   = left_key;
          front_nxt = left_front;
          back_nxt  = left_back;
          ptr_nxt   = left_ptr;
        end
      end
      if (ctrl.grow && at_pos) begin
        if (ctrl.join_front) begin
          front_nxt = front_r - FW'(1);
        end else begin
          back_nxt = back_r + FW'(1);
        end
      end
      if (ctrl.rm) begin
        if (ctrl.del) begin
          if (valid_r && right_valid) begin
            valid_nxt = 1'b1;
            key_nxt   = right_key;
            front_nxt = right_front;
            back_nxt  = right_back;
            ptr_nxt   = right_ptr;
          end else if (valid_r) begin
            // last live node drops out and takes the freed bank
            valid_nxt = 1'b0;
            ptr_nxt   = head_ptr;
          end
        end else if (IDX == 0) begin
          front_nxt = front_r + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ptr_r   <= PW'(IDX);
    end else begin
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
    end
    key_r   <= key_nxt;
    front_r <= front_nxt;
    back_r  <= back_nxt;
  end

  assign valid       = valid_r;
  assign key         = key_r;
  assign front       = front_r;
  assign back        = back_r;
  assign ptr         = ptr_r;
  assign valid_nxt_o = valid_nxt;
  assign key_nxt_o   = key_nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/grouped_key_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// grouped_key_priority_queue_core
// Min-priority queue of key/value pairs held in a sorted chain of node cells.
// ----------------------------------------------------------------------------
// Sequencing: the slot memory read is issued in the accept cycle (idle state);
//   the chain updates in the exec state, which loads the result register.
//   A new item is taken only in the idle state, once the result register is
//   free or its result is being taken, so items do not overlap.
// Reset: clears node valid bits, sets bank pointers to cell index; slot memory,
//   keys and window bounds are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_key_priority_queue_core #(
  parameter int NODE_SLOTS      = gkpq_pkg::NODE_SLOTS_DEF,
  parameter int VALUES_PER_NODE = gkpq_pkg::VALUES_PER_NODE_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  gkpq_in_if.sink    in_chan,
  gkpq_out_if.source out_chan
);

  localparam int PW    = $clog2(NODE_SLOTS);
  localparam int FW    = $clog2(VALUES_PER_NODE + 1);
  localparam int IW    = (VALUES_PER_NODE > 1) ? $clog2(VALUES_PER_NODE) : 1;
  localparam int CW    = $clog2(NODE_SLOTS + 1);
  localparam int DEPTH = NODE_SLOTS * (2 ** IW);
  localparam int KW    = gkpq_pkg::KEY_W;
  localparam int VW    = gkpq_pkg::VAL_W;

  // Sequencer and held item
  gkpq_pkg::state_t state_r, state_nxt;
  logic             op_r;
  logic [KW-1:0]    key_r;
  logic [VW-1:0]    value_r;
  logic [CW-1:0]    count_r, count_nxt;

  // Per-cell views
  logic          c_valid [NODE_SLOTS];
  logic [KW-1:0] c_key   [NODE_SLOTS];
  logic [FW-1:0] c_front [NODE_SLOTS];
  logic [FW-1:0] c_back  [NODE_SLOTS];
  logic [PW-1:0] c_ptr   [NODE_SLOTS];
  logic          c_lt    [NODE_SLOTS];
  logic          c_atpos [NODE_SLOTS];
  logic          c_hit   [NODE_SLOTS];
  logic          c_vn    [NODE_SLOTS];
  logic [KW-1:0] c_kn    [NODE_SLOTS];

  gkpq_pkg::ctrl_t ctrl;
  logic            exec;
  logic            accept;
  logic [PW-1:0]   free_ptr, pos_ptr;
  logic [FW-1:0]   pos_front, pos_back;
  logic            join_hit;
  logic            is_put, is_rm, full_chain, ovf;
  logic [KW-1:0]   last_key_nxt;

  // Slot memory: bank per node pointer, slot index inside the bank
  logic [VW-1:0]    slot_mem [DEPTH];
  logic [VW-1:0]    rdata_r;
  logic [PW+IW-1:0] waddr;
  logic             wen;

  // Output register
  logic          out_valid_r;
  logic [KW-1:0] out_key_r;
  logic [VW-1:0] out_value_r;
  logic          out_empty_r, out_ovf_r, out_empty_now_r, out_two_r;

  assign exec   = (state_r == gkpq_pkg::ST_EXEC);
  // take a new item in the idle state once the result slot frees up in the same edge
  assign in_chan.ready = (state_r == gkpq_pkg::ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept = in_chan.valid && in_chan.ready;

  // Chain of node cells
  for (genvar i = 0; i < NODE_SLOTS; i++) begin : g_cell
    logic          lt_l, lv, rv;
    logic [KW-1:0] lk, rk;
    logic [FW-1:0] lf, lb, rf, rb;
    logic [PW-1:0] lp, rp;

    if (i == 0) begin : g_head
      assign lt_l = 1'b1;
      assign lv   = 1'b0;
      assign lk   = '0;
      assign lf   = '0;
      assign lb   = '0;
      assign lp   = '0;
    end else begin : g_mid
      assign lt_l = c_lt[i-1];
      assign lv   = c_valid[i-1];
      assign lk   = c_key[i-1];
      assign lf   = c_front[i-1];
      assign lb   = c_back[i-1];
      assign lp   = c_ptr[i-1];
    end

    if (i == NODE_SLOTS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rk = '0;
      assign rf = '0;
      assign rb = '0;
      assign rp = '0;
    end else begin : g_nxt
      assign rv = c_valid[i+1];
      assign rk = c_key[i+1];
      assign rf = c_front[i+1];
      assign rb = c_back[i+1];
      assign rp = c_ptr[i+1];
    end

    gkpq_cell #(
      .IDX (i),
      .VPN (VALUES_PER_NODE),
      .PW  (PW),
      .FW  (FW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (exec),
      .ctrl        (ctrl),
      .item_key    (key_r),
      .free_ptr    (free_ptr),
      .head_ptr    (c_ptr[0]),
      .lt_left     (lt_l),
      .left_valid  (lv),
      .left_key    (lk),
      .left_front  (lf),
      .left_back   (lb),
      .left_ptr    (lp),
      .right_valid (rv),
      .right_key   (rk),
      .right_front (rf),
      .right_back  (rb),
      .right_ptr   (rp),
      .valid       (c_valid[i]),
      .key         (c_key[i]),
      .front       (c_front[i]),
      .back        (c_back[i]),
      .ptr         (c_ptr[i]),
      .lt          (c_lt[i]),
      .at_pos      (c_atpos[i]),
      .hit         (c_hit[i]),
      .valid_nxt_o (c_vn[i]),
      .key_nxt_o   (c_kn[i])
    );
  end

  // Gather the found node, the first free bank and the new tail key
  always_comb begin
    free_ptr     = '0;
    pos_ptr      = '0;
    pos_front    = '0;
    pos_back     = '0;
    join_hit     = 1'b0;
    last_key_nxt = '0;
    for (int i = 0; i < NODE_SLOTS; i++) begin
      if (!c_valid[i] && (i == 0 || c_valid[(i == 0) ? 0 : i - 1])) begin
        free_ptr = free_ptr | c_ptr[i];
      end
      if (c_atpos[i]) begin
        pos_ptr   = pos_ptr | c_ptr[i];
        pos_front = pos_front | c_front[i];
        pos_back  = pos_back | c_back[i];
      end
      join_hit = join_hit | c_hit[i];
      if (c_vn[i] && (i == NODE_SLOTS - 1 || !c_vn[(i == NODE_SLOTS - 1) ? i : i + 1])) begin
        last_key_nxt = last_key_nxt | c_kn[i];
      end
    end
  end

  // Decode the command for this item
  assign is_put     = exec && (op_r == gkpq_pkg::OP_PUT);
  assign is_rm      = exec && (op_r == gkpq_pkg::OP_REMOVE) && (count_r != '0);
  assign full_chain = (count_r == CW'(NODE_SLOTS));
  assign ovf        = is_put && !join_hit && full_chain;

  always_comb begin
    ctrl            = '0;
    ctrl.grow       = is_put && join_hit;
    ctrl.join_front = pos_front != '0;
    ctrl.ins        = is_put && !join_hit && !full_chain;
    ctrl.rm         = is_rm;
    ctrl.del        = is_rm && ((c_front[0] + FW'(1)) >= c_back[0]);
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Slot write: front or back of a joined window, or slot zero of a new bank
  always_comb begin
    wen   = ctrl.grow || ctrl.ins;
    waddr = {free_ptr, IW'(0)};
    if (ctrl.grow) begin
      if (ctrl.join_front) begin
        waddr = {pos_ptr, pos_front[IW-1:0] - IW'(1)};
      end else begin
        waddr = {pos_ptr, pos_back[IW-1:0]};
      end
    end
  end

  // Read the head value while the item is taken; chain is stable then
  always_ff @(posedge clk) begin
    if (wen) begin
      slot_mem[waddr] <= value_r;
    end
    if (accept) begin
      rdata_r <= slot_mem[{c_ptr[0], c_front[0][IW-1:0]}];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gkpq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = gkpq_pkg::ST_EXEC;
        end
      end
      gkpq_pkg::ST_EXEC: begin
        state_nxt = gkpq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gkpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gkpq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item and load the result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_chan.op;
      key_r   <= in_chan.item_key;
      value_r <= in_chan.item_value;
    end
    if (exec) begin
      out_key_r       <= '0;
      out_value_r     <= '0;
      out_empty_r     <= 1'b0;
      out_ovf_r       <= ovf;
      out_empty_now_r <= (count_nxt == '0);
      out_two_r       <= (count_nxt != '0) && (last_key_nxt != c_kn[0]);
      if (op_r == gkpq_pkg::OP_REMOVE) begin
        if (count_r == '0) begin
          out_key_r   <= '1;
          out_empty_r <= 1'b1;
        end else begin
          out_key_r   <= c_key[0];
          out_value_r <= rdata_r;
        end
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.key_out           = out_key_r;
  assign out_chan.value_out         = out_value_r;
  assign out_chan.was_empty         = out_empty_r;
  assign out_chan.overflow          = out_ovf_r;
  assign out_chan.empty_now         = out_empty_now_r;
  assign out_chan.two_distinct_keys = out_two_r;

endmodule

`default_nettype wire
